>>> rtl/core/wtc_pkg.sv
// types and constants shared by the wall texture column unit
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package wtc_pkg;

    localparam int CFG_SH_W   = 12;
    localparam int CFG_TEX_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 2'd2;

    localparam logic [CFG_SH_W-1:0]  RST_VIEW_ROWS      = 12'd480;
    localparam logic [CFG_TEX_W-1:0] RST_TEXTURE_WIDTH  = 13'd64;
    localparam logic [CFG_TEX_W-1:0] RST_TEXTURE_HEIGHT = 13'd64;

    localparam logic CMD_SETUP = 1'b0;
    localparam logic CMD_ROW   = 1'b1;

    localparam logic SIDE_VERTICAL = 1'b0;

    localparam logic [1:0] KIND_WALL = 2'd0;
    localparam logic [1:0] KIND_DOOR = 2'd1;

    localparam logic [2:0] TEX_WEST   = 3'd0;
    localparam logic [2:0] TEX_EAST   = 3'd1;
    localparam logic [2:0] TEX_NORTH  = 3'd2;
    localparam logic [2:0] TEX_SOUTH  = 3'd3;
    localparam logic [2:0] TEX_DOOR   = 3'd4;
    localparam logic [2:0] TEX_PORTAL = 3'd5;

    typedef struct packed {
        logic               command;
        logic               grid_side;
        logic [1:0]         wall_kind;
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic [23:0]        pos_x;
        logic [23:0]        pos_y;
        logic [23:0]        distance;
        logic [11:0]        slice_start;
        logic [11:0]        slice_end;
        logic [15:0]        slice_height;
        logic [11:0]        column;
    } wtc_in_t;

    typedef struct packed {
        logic [2:0]  texture_id;
        logic [11:0] texel_x;
        logic [11:0] texel_y;
        logic [23:0] texel_index;
        logic [11:0] screen_row;
        logic [11:0] screen_column;
        logic        pixel_valid;
        logic        slice_done;
    } wtc_out_t;

    typedef struct packed {
        logic [CFG_SH_W-1:0]  view_rows;
        logic [CFG_TEX_W-1:0] texture_width;
        logic [CFG_TEX_W-1:0] texture_height;
    } wtc_cfg_t;

    typedef struct packed {
        logic load_item;
        logic ray_mul;
        logic div_start;
        logic frac_mul;
        logic mirror;
        logic pos_mul;
        logic setup_out;
        logic row_calc;
        logic row_out;
    } wtc_cmd_t;

    typedef struct packed {
        logic new_is_row;
        logic div_done;
        logic out_free;
    } wtc_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/raycast_wall_texture_column_top.sv
// top level of the raycaster wall texture column unit
// depends on wtc_pkg, wtc_ctrl, wtc_dp (and wtc_div inside the datapath)
//
// One request in, one result out. A column-setup request (command 0) picks the
// wall texture, computes the texture column (mirrored where the ray direction
// needs it) and the per-row texture step, and answers with the column header;
// its longest step is the bit-serial divider that forms texture_height * 2^16 /
// slice_height one quotient bit per cycle. A row-step request (command 1) is
// accepted, then clamps and advances the texture position, then forms the texel
// index with one small multiply. Requests are taken one at a time; the next
// request is accepted while a result still sits in the output register.
// Configuration writes are always accepted and should be issued only while the
// block is idle.
`default_nettype none

module raycast_wall_texture_column_top import wtc_pkg::*; #(
    parameter int ROW_BITS = 12,
    parameter int TEX_BITS = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // item requests
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire wtc_in_t               s_data,
    // result requests
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output wtc_out_t                   m_data,
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    wtc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.view_rows      <= RST_VIEW_ROWS;
            cfg_reg.texture_width  <= RST_TEXTURE_WIDTH;
            cfg_reg.texture_height <= RST_TEXTURE_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_VIEW_ROWS:      cfg_reg.view_rows      <= cfg_data[CFG_SH_W-1:0];
                CFG_TEXTURE_WIDTH:  cfg_reg.texture_width  <= cfg_data[CFG_TEX_W-1:0];
                CFG_TEXTURE_HEIGHT: cfg_reg.texture_height <= cfg_data[CFG_TEX_W-1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    // controller and datapath talk only through these
    wtc_cmd_t  cmd;
    wtc_stat_t stat;

    wtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wtc_dp #(
        .ROW_BITS (ROW_BITS),
        .TEX_BITS (TEX_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    // one request at a time: the port closes right after an accept
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request is in flight");

    // the last pixel flag only rides on a real pixel
    a_done_has_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.slice_done) |-> m_data.pixel_valid)
        else $error("slice_done without pixel_valid");

    // headers and out-of-slice steps carry no texel row
    a_no_pixel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.pixel_valid) |->
            (m_data.texel_y == '0 && m_data.texel_index == '0))
        else $error("texel fields set on a result without a pixel");
`endif

endmodule

`default_nettype wire

>>> rtl/core/wtc_div.sv
// restoring unsigned divider, one quotient bit per cycle
// standalone; used by the datapath for the per-row texture step
`default_nettype none

module wtc_div #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/wtc_ctrl.sv
// sequencer for column setup and row step requests
// uses wtc_pkg command and status structs; drives the datapath and s_ready
`default_nettype none

module wtc_ctrl import wtc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire wtc_stat_t stat,
    output wtc_cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RAY_MUL   = 4'd1;
    localparam logic [3:0] ST_FRAC_MUL  = 4'd2;
    localparam logic [3:0] ST_MIRROR    = 4'd3;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd4;
    localparam logic [3:0] ST_POS_MUL   = 4'd5;
    localparam logic [3:0] ST_SETUP_OUT = 4'd6;
    localparam logic [3:0] ST_ROW_CALC  = 4'd7;
    localparam logic [3:0] ST_ROW_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.new_is_row ? ST_ROW_CALC : ST_RAY_MUL;
                end
            end
            ST_RAY_MUL:  state_next = ST_FRAC_MUL;
            ST_FRAC_MUL: state_next = ST_MIRROR;
            ST_MIRROR:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_POS_MUL;
                end
            end
            ST_POS_MUL:  state_next = ST_SETUP_OUT;
            ST_SETUP_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROW_CALC: state_next = ST_ROW_OUT;
            ST_ROW_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        cmd           = '0;
        cmd.load_item = (state_reg == ST_IDLE) && s_valid;
        cmd.ray_mul   = state_reg == ST_RAY_MUL;
        cmd.div_start = state_reg == ST_RAY_MUL;
        cmd.frac_mul  = state_reg == ST_FRAC_MUL;
        cmd.mirror    = state_reg == ST_MIRROR;
        cmd.pos_mul   = state_reg == ST_POS_MUL;
        cmd.setup_out = (state_reg == ST_SETUP_OUT) && stat.out_free;
        cmd.row_calc  = state_reg == ST_ROW_CALC;
        cmd.row_out   = (state_reg == ST_ROW_OUT) && stat.out_free;
    end

endmodule

`default_nettype wire

>>> rtl/core/wtc_dp.sv
// datapath: column state, multipliers, row stepping and the result register
// uses wtc_pkg types; instantiates wtc_div for the texture step
`default_nettype none

module wtc_dp import wtc_pkg::*; #(
    parameter int ROW_BITS = 12,
    parameter int TEX_BITS = 12
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire wtc_cfg_t cfg,
    input  wire wtc_in_t  s_data,
    input  wire wtc_cmd_t cmd,
    output wtc_stat_t     stat,
    input  wire logic     m_ready,
    output logic          m_valid,
    output wtc_out_t      m_data
);

    localparam int TW    = TEX_BITS + 1;
    localparam int QW    = TEX_BITS + 17;
    localparam int OFS_W = 18;
    localparam int PW    = OFS_W + QW + 1;
    localparam int FPW   = 16 + TW;
    localparam int IW    = 2 * TEX_BITS + 1;
    localparam logic [TW-1:0] TEX_MAX = TW'(1) << TEX_BITS;

    wtc_in_t item_reg;

    logic [TW-1:0] tw, th;
    logic [15:0]   h_fix;

    // texture sizes saturated to 1 .. 2^TEX_BITS
    always_comb begin
        if (cfg.texture_width == '0) begin
            tw = TW'(1);
        end else if (cfg.texture_width > CFG_TEX_W'(TEX_MAX)) begin
            tw = TEX_MAX;
        end else begin
            tw = TW'(cfg.texture_width);
        end
        if (cfg.texture_height == '0) begin
            th = TW'(1);
        end else if (cfg.texture_height > CFG_TEX_W'(TEX_MAX)) begin
            th = TEX_MAX;
        end else begin
            th = TW'(cfg.texture_height);
        end
    end

    assign h_fix = (item_reg.slice_height == '0) ? 16'd1 : item_reg.slice_height;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
    end

    // texture selection
    logic [2:0] tid;
    always_comb begin
        case (item_reg.wall_kind)
            KIND_WALL: begin
                if (item_reg.grid_side == SIDE_VERTICAL) begin
                    tid = item_reg.ray_dir_x[15] ? TEX_WEST : TEX_EAST;
                end else begin
                    tid = item_reg.ray_dir_y[15] ? TEX_NORTH : TEX_SOUTH;
                end
            end
            KIND_DOOR: tid = TEX_DOOR;
            default:   tid = TEX_PORTAL;
        endcase
    end

    // wall hit: base << 12 plus distance * ray, only the low 28 bits matter
    logic signed [15:0] ray_sel;
    logic signed [40:0] ray_full;
    logic [27:0]        ray_prod_reg;
    logic [23:0]        base_sel;
    logic [27:0]        hit_sum;
    logic [15:0]        frac;
    logic [FPW-1:0]     frac_prod_reg;
    logic [TEX_BITS-1:0] tx_raw, tx_reg;
    logic               mirror_x;

    assign ray_sel  = (item_reg.grid_side == SIDE_VERTICAL) ? item_reg.ray_dir_y
                                                            : item_reg.ray_dir_x;
    assign base_sel = (item_reg.grid_side == SIDE_VERTICAL) ? item_reg.pos_y : item_reg.pos_x;
    assign ray_full = $signed({1'b0, item_reg.distance}) * ray_sel;
    assign hit_sum  = {base_sel[15:0], 12'd0} + ray_prod_reg;
    assign frac     = hit_sum[27:12];
    assign tx_raw   = frac_prod_reg[16 +: TEX_BITS];
    assign mirror_x = ((item_reg.grid_side == SIDE_VERTICAL) && item_reg.ray_dir_x[15])
                   || ((item_reg.grid_side != SIDE_VERTICAL) && !item_reg.ray_dir_y[15]
                       && (item_reg.ray_dir_y != '0));

    always_ff @(posedge aclk) begin
        if (cmd.ray_mul) begin
            ray_prod_reg <= ray_full[27:0];
        end
        if (cmd.frac_mul) begin
            frac_prod_reg <= FPW'(frac) * FPW'(tw);
        end
        if (cmd.mirror) begin
            tx_reg <= mirror_x ? TEX_BITS'(tw - TW'(tx_raw) - TW'(1)) : tx_raw;
        end
    end

    // texture step division
    logic          div_done;
    logic [QW-1:0] div_q;

    wtc_div #(
        .DVD_W (QW),
        .DVS_W (16)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({th, 16'd0}),
        .divisor  (h_fix),
        .done     (div_done),
        .quotient (div_q)
    );

    // starting texture position
    logic [ROW_BITS-1:0]     start_row;
    logic signed [OFS_W-1:0] offset;
    logic signed [PW-1:0]    pos_full;
    logic signed [PW-1:0]    pos_prod_reg;
    logic [PW-32:0]          pos_upper;
    logic [31:0]             pos_sat;

    assign start_row = ROW_BITS'(item_reg.slice_start);
    assign offset    = $signed(OFS_W'(start_row))
                     - $signed(OFS_W'(cfg.view_rows >> 1))
                     + $signed(OFS_W'(h_fix >> 1));
    assign pos_full  = offset * $signed({1'b0, div_q});
    assign pos_upper = pos_prod_reg[PW-1:31];
    assign pos_sat   = ((&pos_upper) || !(|pos_upper)) ? pos_prod_reg[31:0]
                     : (pos_prod_reg[PW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_ff @(posedge aclk) begin
        if (cmd.pos_mul) begin
            pos_prod_reg <= pos_full;
        end
    end

    // column state
    logic [31:0]         tex_pos_reg;
    logic [QW-1:0]       row_step_reg;
    logic [ROW_BITS-1:0] cur_row_reg, end_row_reg;
    logic [TEX_BITS-1:0] held_tx_reg;
    logic [2:0]          held_tid_reg;
    logic [11:0]         held_col_reg;

    // row step
    logic                in_slice;
    logic [14:0]         tpos_int;
    logic [TEX_BITS-1:0] ty;
    logic signed [32:0]  step_sum;
    logic [31:0]         step_sat;
    logic                row_done;
    logic [TEX_BITS-1:0] ty_reg;
    logic                slice_reg, done_reg;
    logic [ROW_BITS-1:0] row_num_reg;
    logic [IW-1:0]       idx;

    assign in_slice = cur_row_reg < end_row_reg;
    assign tpos_int = tex_pos_reg[30:16];
    assign step_sum = $signed({tex_pos_reg[31], tex_pos_reg}) + $signed(33'(row_step_reg));
    assign step_sat = (step_sum[32] != step_sum[31])
                    ? (step_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : step_sum[31:0];
    assign row_done = ((ROW_BITS+1)'(cur_row_reg) + (ROW_BITS+1)'(1))
                   == (ROW_BITS+1)'(end_row_reg);
    assign idx      = IW'(ty_reg) * IW'(tw) + IW'(held_tx_reg);

    always_comb begin
        if (tex_pos_reg[31]) begin
            ty = '0;
        end else if ({1'b0, tpos_int} >= 16'(th)) begin
            ty = TEX_BITS'(th - TW'(1));
        end else begin
            ty = TEX_BITS'(tpos_int);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_pos_reg  <= '0;
            row_step_reg <= '0;
            cur_row_reg  <= '0;
            end_row_reg  <= '0;
            held_tx_reg  <= '0;
            held_tid_reg <= '0;
            held_col_reg <= '0;
        end else if (cmd.setup_out) begin
            tex_pos_reg  <= pos_sat;
            row_step_reg <= div_q;
            cur_row_reg  <= start_row;
            end_row_reg  <= ROW_BITS'(item_reg.slice_end);
            held_tx_reg  <= tx_reg;
            held_tid_reg <= tid;
            held_col_reg <= item_reg.column;
        end else if (cmd.row_calc && in_slice) begin
            tex_pos_reg <= step_sat;
            cur_row_reg <= cur_row_reg + ROW_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_calc) begin
            ty_reg      <= ty;
            slice_reg   <= in_slice;
            done_reg    <= in_slice && row_done;
            row_num_reg <= cur_row_reg;
        end
    end

    // result register
    logic     m_valid_reg;
    wtc_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.setup_out || cmd.row_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup_out) begin
            m_data_reg.texture_id    <= tid;
            m_data_reg.texel_x       <= 12'(tx_reg);
            m_data_reg.texel_y       <= '0;
            m_data_reg.texel_index   <= '0;
            m_data_reg.screen_row    <= 12'(start_row);
            m_data_reg.screen_column <= item_reg.column;
            m_data_reg.pixel_valid   <= 1'b0;
            m_data_reg.slice_done    <= 1'b0;
        end else if (cmd.row_out) begin
            m_data_reg.texture_id    <= held_tid_reg;
            m_data_reg.texel_x       <= 12'(held_tx_reg);
            m_data_reg.texel_y       <= slice_reg ? 12'(ty_reg) : 12'd0;
            m_data_reg.texel_index   <= slice_reg ? 24'(idx) : 24'd0;
            m_data_reg.screen_row    <= 12'(row_num_reg);
            m_data_reg.screen_column <= held_col_reg;
            m_data_reg.pixel_valid   <= slice_reg;
            m_data_reg.slice_done    <= done_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign stat.new_is_row = s_data.command == CMD_ROW;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule

`default_nettype wire
